// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

// Next-cycle implication that also holds through reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/esfe_pkg.sv =====
package esfe_pkg;

   localparam int DEF_BUFFER_BYTES = 1024;
   localparam int DEF_VALUE_SLOTS  = 32;
   localparam int DEF_VALUE_BYTES  = 32;
   localparam int QUEUE_DEPTH      = 2;
   localparam int REQ_DATA_W       = 24;
   localparam int RSP_DATA_W       = 16;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_I     = 8'h49;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_V     = 8'h56;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_BRACE = 8'h7b;
   localparam logic [7:0] CH_BAR   = 8'h7c;

   typedef enum logic {
      KIND_FEED,
      KIND_READ
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic       chunk_end;
      logic [4:0] slot;
      logic [4:0] position;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EVAL,
      ST_TERM,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_FIND,
      PH_DIGIT,
      PH_SKIP,
      PH_COPY
   } phase_type;

   function automatic logic is_stop(logic [7:0] c);
      is_stop = (c == CH_BRACE) || (c == CH_CR) || (c == CH_LF) || (c == CH_BAR);
   endfunction

endpackage

// ===== hw/rtl/esfe_front.sv =====
module esfe_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [esfe_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   input  logic [0:0]                          req_tuser,
   output logic                                q_valid,
   output esfe_pkg::item_type                  q_item,
   input  logic                                q_pop
);

   localparam int QD  = esfe_pkg::QUEUE_DEPTH;
   localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
   localparam int CW  = $clog2(QD + 1);

   esfe_pkg::item_type entry_ff [QD];
   esfe_pkg::item_type in_item;
   logic [QAW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           push, pop;

   // Classify the beat: selector bit picks feed or read.
   always_comb begin
      in_item.kind      = req_tuser[0] ? esfe_pkg::KIND_READ : esfe_pkg::KIND_FEED;
      in_item.data_byte = req_tdata[7:0];
      in_item.chunk_end = req_tlast;
      in_item.slot      = req_tdata[12:8];
      in_item.position  = req_tdata[17:13];
   end

   assign req_tready = (count_ff != CW'(QD));
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && q_valid;
   assign q_valid    = (count_ff != '0);
   assign q_item     = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == QAW'(QD - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == QAW'(QD - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= in_item;
      end
   end

endmodule

// ===== hw/rtl/esfe_back.sv =====
module esfe_back #(
   parameter int BUFFER_BYTES = esfe_pkg::DEF_BUFFER_BYTES,
   parameter int VALUE_SLOTS  = esfe_pkg::DEF_VALUE_SLOTS,
   parameter int VALUE_BYTES  = esfe_pkg::DEF_VALUE_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   input  esfe_pkg::item_type                  q_item,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [esfe_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int LW   = $clog2(BUFFER_BYTES);
   localparam int SLW  = (VALUE_SLOTS > 1) ? $clog2(VALUE_SLOTS) : 1;
   localparam int VW   = $clog2(VALUE_BYTES);
   localparam int SAW  = $clog2(VALUE_SLOTS * VALUE_BYTES);
   localparam int NUMW = $clog2(VALUE_SLOTS * 10);

   // Line buffer and value store.
   logic [7:0] lbuf [BUFFER_BYTES];
   logic [7:0] vstore [VALUE_SLOTS * VALUE_BYTES];
   logic [7:0] lq_ff, vq_ff;

   logic           lb_we, lb_re;
   logic [7:0]     lb_wdata;
   logic           vs_we, vs_re;
   logic [SAW-1:0] vs_waddr, vs_raddr;
   logic [7:0]     vs_wdata;

   esfe_pkg::state_type state_ff, state_in;
   esfe_pkg::phase_type phase_ff, phase_in;

   logic [LW-1:0]   len_ff, len_in, p_ff, p_in, dpos_ff, dpos_in;
   logic [NUMW-1:0] num_ff, num_in;
   logic            got_ff, got_in, eof_ff, eof_in;
   logic [1:0]      m_ff, m_in;
   logic [VW-1:0]   vi_ff, vi_in;
   logic            zseen_ff, zseen_in, bnd_ff, bnd_in, dfound_ff, dfound_in;
   logic [7:0]      hist_ff [4];
   logic [7:0]      hist_in [4];
   logic            commit_ff, commit_in, isread_ff, isread_in;
   logic            rdok_ff, rdok_in, posok_ff, posok_in, sv_ff, sv_in;
   logic            valid_ff [VALUE_SLOTS];
   logic            valid_set;
   logic [SLW-1:0]  valid_idx;

   logic            rsp_valid_ff, rsp_valid_in, rsp_commit_ff, rsp_sv_ff;
   logic [7:0]      rsp_byte_ff;
   logic            rsp_load;

   logic [7:0]      c, diff;
   logic [NUMW-1:0] num_t;
   logic [LW-1:0]   len_n;
   logic            wr, bnd_n, dfound_n;
   logic [LW-1:0]   dpos_n;
   logic [SLW-1:0]  cur_slot;

   function automatic logic [SAW-1:0] saddr(logic [SLW-1:0] s, logic [VW-1:0] v);
      saddr = SAW'(s) * SAW'(VALUE_BYTES) + SAW'(v);
   endfunction

   assign c        = lq_ff;
   assign diff     = c - esfe_pkg::CH_ZERO;
   assign cur_slot = SLW'(num_ff);
   assign num_t    = NUMW'(num_ff * NUMW'(10)) + NUMW'(diff[3:0]);

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      len_in    = len_ff;
      p_in      = p_ff;
      dpos_in   = dpos_ff;
      num_in    = num_ff;
      got_in    = got_ff;
      eof_in    = eof_ff;
      m_in      = m_ff;
      vi_in     = vi_ff;
      zseen_in  = zseen_ff;
      bnd_in    = bnd_ff;
      dfound_in = dfound_ff;
      hist_in   = hist_ff;
      commit_in = commit_ff;
      isread_in = isread_ff;
      rdok_in   = rdok_ff;
      posok_in  = posok_ff;
      sv_in     = sv_ff;
      q_pop     = 1'b0;
      lb_we     = 1'b0;
      lb_re     = 1'b0;
      lb_wdata  = q_item.data_byte;
      vs_we     = 1'b0;
      vs_re     = 1'b0;
      vs_waddr  = saddr(cur_slot, vi_ff);
      vs_raddr  = saddr(SLW'(q_item.slot), VW'(q_item.position));
      vs_wdata  = c;
      valid_set = 1'b0;
      valid_idx = cur_slot;
      rsp_load  = 1'b0;
      len_n     = len_ff;
      bnd_n     = bnd_ff;
      dfound_n  = dfound_ff;
      dpos_n    = dpos_ff;
      wr        = 1'b0;

      unique case (state_ff)
         esfe_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.kind == esfe_pkg::KIND_READ) begin
                  isread_in = 1'b1;
                  commit_in = 1'b0;
                  rdok_in   = (32'(q_item.slot) < VALUE_SLOTS);
                  posok_in  = (32'(q_item.position) < VALUE_BYTES);
                  sv_in     = (32'(q_item.slot) < VALUE_SLOTS) ?
                              valid_ff[SLW'(q_item.slot)] : 1'b0;
                  vs_re     = 1'b1;
                  state_in  = esfe_pkg::ST_DONE;
               end else begin
                  isread_in = 1'b0;
                  wr = (len_ff < LW'(BUFFER_BYTES - 1));
                  if (wr) begin
                     lb_we = 1'b1;
                     len_n = len_ff + 1'b1;
                     hist_in[0] = q_item.data_byte;
                     hist_in[1] = hist_ff[0];
                     hist_in[2] = hist_ff[1];
                     hist_in[3] = hist_ff[2];
                     // Track boundary and "data:" up to the first zero byte.
                     if (!zseen_ff && q_item.data_byte != esfe_pkg::CH_NUL) begin
                        if ((hist_ff[0] == esfe_pkg::CH_LF &&
                             q_item.data_byte == esfe_pkg::CH_LF) ||
                            (hist_ff[2] == esfe_pkg::CH_CR && hist_ff[1] == esfe_pkg::CH_LF &&
                             hist_ff[0] == esfe_pkg::CH_CR &&
                             q_item.data_byte == esfe_pkg::CH_LF)) begin
                           bnd_n = 1'b1;
                        end
                        if (!dfound_ff && hist_ff[3] == esfe_pkg::CH_D &&
                            hist_ff[2] == esfe_pkg::CH_A && hist_ff[1] == esfe_pkg::CH_T &&
                            hist_ff[0] == esfe_pkg::CH_A &&
                            q_item.data_byte == esfe_pkg::CH_COLON) begin
                           dfound_n = 1'b1;
                           dpos_n   = len_ff - LW'(4);
                        end
                     end
                     if (q_item.data_byte == esfe_pkg::CH_NUL) begin
                        zseen_in = 1'b1;
                     end
                  end
                  len_in    = len_n;
                  bnd_in    = bnd_n;
                  dfound_in = dfound_n;
                  dpos_in   = dpos_n;
                  commit_in = 1'b0;
                  state_in  = esfe_pkg::ST_DONE;
                  if (q_item.chunk_end && (bnd_n || len_n >= LW'(BUFFER_BYTES - 2))) begin
                     commit_in = 1'b1;
                     if (dfound_n) begin
                        p_in     = dpos_n + LW'(5);
                        phase_in = esfe_pkg::PH_SPACE;
                        state_in = esfe_pkg::ST_FETCH;
                     end else begin
                        len_in    = '0;
                        zseen_in  = 1'b0;
                        bnd_in    = 1'b0;
                        dfound_in = 1'b0;
                        hist_in   = '{default: 8'h00};
                     end
                  end
               end
            end
         end

         esfe_pkg::ST_FETCH: begin
            eof_in   = (p_ff >= len_ff);
            lb_re    = (p_ff < len_ff);
            state_in = esfe_pkg::ST_EVAL;
         end

         esfe_pkg::ST_EVAL: begin
            state_in = esfe_pkg::ST_FETCH;
            unique case (phase_ff)
               esfe_pkg::PH_SPACE: begin
                  if (!eof_ff && c == esfe_pkg::CH_SPACE) begin
                     p_in = p_ff + 1'b1;
                  end else begin
                     phase_in = esfe_pkg::PH_FIND;
                     m_in     = 2'd0;
                  end
               end
               esfe_pkg::PH_FIND: begin
                  if (eof_ff || c == esfe_pkg::CH_NUL) begin
                     // Text exhausted: clear the buffer and report the commit.
                     len_in    = '0;
                     zseen_in  = 1'b0;
                     bnd_in    = 1'b0;
                     dfound_in = 1'b0;
                     hist_in   = '{default: 8'h00};
                     state_in  = esfe_pkg::ST_DONE;
                  end else begin
                     p_in = p_ff + 1'b1;
                     if (m_ff == 2'd2 && c == esfe_pkg::CH_V) begin
                        phase_in = esfe_pkg::PH_DIGIT;
                        num_in   = '0;
                        got_in   = 1'b0;
                     end else begin
                        case (m_ff)
                           2'd0:    m_in = (c == esfe_pkg::CH_S) ? 2'd1 : 2'd0;
                           2'd1:    m_in = (c == esfe_pkg::CH_I) ? 2'd2 :
                                           ((c == esfe_pkg::CH_S) ? 2'd1 : 2'd0);
                           default: m_in = (c == esfe_pkg::CH_S) ? 2'd1 : 2'd0;
                        endcase
                     end
                  end
               end
               esfe_pkg::PH_DIGIT: begin
                  if (!eof_ff && c >= esfe_pkg::CH_ZERO && c <= esfe_pkg::CH_NINE) begin
                     if (num_ff < NUMW'(VALUE_SLOTS)) begin
                        num_in = (num_t > NUMW'(VALUE_SLOTS)) ? NUMW'(VALUE_SLOTS) : num_t;
                     end
                     got_in = 1'b1;
                     p_in   = p_ff + 1'b1;
                  end else if (got_ff && num_ff < NUMW'(VALUE_SLOTS)) begin
                     phase_in = esfe_pkg::PH_SKIP;
                  end else begin
                     phase_in = esfe_pkg::PH_FIND;
                     m_in     = 2'd0;
                  end
               end
               esfe_pkg::PH_SKIP: begin
                  if (eof_ff) begin
                     phase_in = esfe_pkg::PH_FIND;
                     m_in     = 2'd0;
                  end else begin
                     p_in = p_ff + 1'b1;
                     if (c == esfe_pkg::CH_BAR) begin
                        vi_in    = '0;
                        phase_in = esfe_pkg::PH_COPY;
                     end
                  end
               end
               esfe_pkg::PH_COPY: begin
                  if (eof_ff || esfe_pkg::is_stop(c) || vi_ff == VW'(VALUE_BYTES - 1)) begin
                     state_in = esfe_pkg::ST_TERM;
                  end else begin
                     vs_we = 1'b1;
                     vi_in = vi_ff + 1'b1;
                     p_in  = p_ff + 1'b1;
                  end
               end
               default: begin
                  phase_in = esfe_pkg::PH_FIND;
               end
            endcase
         end

         esfe_pkg::ST_TERM: begin
            // Write the terminator; a slot's first write zero-fills its tail.
            vs_we    = 1'b1;
            vs_wdata = esfe_pkg::CH_NUL;
            if (!valid_ff[cur_slot] && vi_ff != VW'(VALUE_BYTES - 1)) begin
               vi_in = vi_ff + 1'b1;
            end else begin
               valid_set = 1'b1;
               phase_in  = esfe_pkg::PH_FIND;
               m_in      = 2'd0;
               state_in  = esfe_pkg::ST_FETCH;
            end
         end

         esfe_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = esfe_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = esfe_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= esfe_pkg::ST_IDLE;
         phase_ff     <= esfe_pkg::PH_FIND;
         len_ff       <= '0;
         zseen_ff     <= 1'b0;
         bnd_ff       <= 1'b0;
         dfound_ff    <= 1'b0;
         hist_ff      <= '{default: 8'h00};
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < VALUE_SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         zseen_ff     <= zseen_in;
         bnd_ff       <= bnd_in;
         dfound_ff    <= dfound_in;
         hist_ff      <= hist_in;
         rsp_valid_ff <= rsp_valid_in;
         if (valid_set) begin
            valid_ff[valid_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff      <= p_in;
      dpos_ff   <= dpos_in;
      num_ff    <= num_in;
      got_ff    <= got_in;
      eof_ff    <= eof_in;
      m_ff      <= m_in;
      vi_ff     <= vi_in;
      commit_ff <= commit_in;
      isread_ff <= isread_in;
      rdok_ff   <= rdok_in;
      posok_ff  <= posok_in;
      sv_ff     <= sv_in;
      if (rsp_load) begin
         rsp_commit_ff <= commit_ff;
         // A slot never written reads as zero; its store bytes are not yet defined.
         rsp_byte_ff   <= (isread_ff && rdok_ff && posok_ff && sv_ff) ? vq_ff : 8'h00;
         rsp_sv_ff     <= isread_ff && sv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (lb_we) begin
         lbuf[len_ff] <= lb_wdata;
      end
      if (lb_re) begin
         lq_ff <= lbuf[p_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (vs_we) begin
         vstore[vs_waddr] <= vs_wdata;
      end
      if (vs_re) begin
         vq_ff <= vstore[vs_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_sv_ff, rsp_byte_ff, rsp_commit_ff};

endmodule

// ===== hw/rtl/event_stream_field_extractor.sv =====
// Event stream field extractor. Feed beats (tuser 0) append one byte to a line buffer of
// BUFFER_BYTES-1 usable bytes and return committed; at a beat marked tlast the buffer is
// parsed when it holds a blank line or is nearly full, the "SIV<n>|value" fields after
// "data:" are copied into VALUE_SLOTS slots of VALUE_BYTES bytes, and the buffer clears.
// Read beats (tuser 1) return one stored byte and the slot's valid bit; a slot never
// written reads as zero. Every beat yields exactly one response. A committing feed beat
// fetches buffer bytes through one line buffer read port, one byte per fetch; a byte is
// fetched again after each change of scan phase and one more fetch finds the end of the
// text. The engine writes a terminator for each value and, on a slot's first write,
// zero-fills the slot's tail bytes. A two-beat input queue takes beats, until it is full,
// while the engine walks or a response waits in the output register. No clearing pass
// after reset.
module event_stream_field_extractor #(
   parameter int BUFFER_BYTES = esfe_pkg::DEF_BUFFER_BYTES,
   parameter int VALUE_SLOTS  = esfe_pkg::DEF_VALUE_SLOTS,
   parameter int VALUE_BYTES  = esfe_pkg::DEF_VALUE_BYTES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // data_byte[7:0], slot[12:8], position[17:13], zero pad
   input  logic [esfe_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,   // chunk_end
   input  logic [0:0]                        req_tuser,   // func
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // committed[0], read_byte[8:1], slot_valid[9], zero pad
   output logic [esfe_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   esfe_pkg::item_type q_item;
   logic               q_valid, q_pop;

   // Front: accept and classify beats into the queue.
   esfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // Back: buffer, parse engine, value store and response register.
   esfe_back #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .VALUE_SLOTS  (VALUE_SLOTS),
      .VALUE_BYTES  (VALUE_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== hw/rtl/esfe_checker.sv =====
`include "assert_macros.svh"

module esfe_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [esfe_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   `ASSERT_NEXT_ALWAYS(a_rsp_idle_after_reset, clock, reset, !rsp_tvalid)

   `ASSERT_NEXT_ALWAYS(a_req_ready_after_reset, clock, reset, req_tready)

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   `ASSERT_IMPLY(a_rsp_pad_zero, clock, reset, rsp_tvalid, rsp_tdata[15:10] == 6'd0)

   `ASSERT_IMPLY(a_commit_no_read, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[9:1] == 9'd0)

endmodule

bind event_stream_field_extractor esfe_checker u_esfe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
